// ===== src/box_blur_3x3_stream_assert.svh =====
// ---------------------------------------------------------------------------
// Box blur assertion macros
// Shared assertion forms for the box blur checker.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_STREAM_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_ASSERT_SVH

// same-cycle implication
`define BB3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("box blur check failed");

// next-cycle implication
`define BB3_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("box blur check failed");

`endif

// ===== src/bb3_pkg.sv =====
// ---------------------------------------------------------------------------
// Box blur package
// Shared widths, constants, types and the divide-by-three helper.
// ---------------------------------------------------------------------------
package bb3_pkg;

  localparam int BB3_PIX_W         = 8;
  localparam int BB3_CFG_W         = 13;
  localparam int BB3_ROW_W         = 12;
  localparam int BB3_MAX_WIDTH_DEF = 4096;
  localparam int BB3_MAX_HEIGHT    = 4096;
  localparam int BB3_MIN_DIM       = 3;
  localparam int BB3_WIDTH_RST     = 640;
  localparam int BB3_HEIGHT_RST    = 480;
  localparam int BB3_Q_DEPTH       = 4;
  localparam int BB3_Q_PTR_W       = $clog2(BB3_Q_DEPTH);
  localparam int BB3_Q_CNT_W       = BB3_Q_PTR_W + 1;

  // configuration register indexes
  typedef enum logic [0:0] {
    BB3_CFG_FRAME_WIDTH  = 1'b0,
    BB3_CFG_FRAME_HEIGHT = 1'b1
  } bb3_cfg_idx_t;

  // one result word
  typedef struct packed {
    logic [BB3_PIX_W-1:0] blurred;
    logic                 end_of_row;
    logic                 end_of_frame;
  } bb3_result_t;

  // one line store entry: horizontal results of the two previous rows
  typedef struct packed {
    logic [BB3_PIX_W-1:0] row_above;
    logic [BB3_PIX_W-1:0] two_above;
  } bb3_lines_t;

  // floor(x/3) for x < 768: x*683 >> 11
  function automatic logic [BB3_PIX_W-1:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * 21'd683;
    return prod[18:11];
  endfunction

endpackage

// ===== src/bb3_line_store.sv =====
// ---------------------------------------------------------------------------
// Box blur line store
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bb3_line_store
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = BB3_MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output bb3_lines_t                   rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  bb3_lines_t                   wr_data
);

  bb3_lines_t mem [MAX_WIDTH];
  bb3_lines_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/bb3_out_queue.sv =====
// ---------------------------------------------------------------------------
// Box blur output queue
// Small register FIFO that decouples the pipeline from receiver stalls.
// ---------------------------------------------------------------------------
module bb3_out_queue
  import bb3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bb3_result_t            push_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bb3_result_t            out_data,
  output logic [BB3_Q_CNT_W-1:0] count
);

  bb3_result_t            q_r [BB3_Q_DEPTH];
  logic [BB3_Q_PTR_W-1:0] wr_ptr_r;
  logic [BB3_Q_PTR_W-1:0] rd_ptr_r;
  logic [BB3_Q_CNT_W-1:0] cnt_r;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = q_r[rd_ptr_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      // count holds when both or neither happen
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/box_blur_3x3_stream.sv =====
// ---------------------------------------------------------------------------
// 3x3 separable box blur, streaming
// Raster grey pixels in, interior blurred pixels out, one two-row line store.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one grey pixel word per handshake, raster order; in_start_of_frame
//           forces the word to position (0,0).
//   out_* : one blurred word per interior position, (width-2) x (height-2)
//           words per frame, flagged end_of_row / end_of_frame.
//   cfg_* : frame_width (index 0) and frame_height (index 1); write only while
//           idle. Values are clamped to 3..MAX_WIDTH and 3..4096.
// Throughput: one word per cycle while in_ready holds, set by the line store,
//   which takes one read (at accept) and one write (next cycle) per word.
// Path: an accepted word is registered in stage 1, then its result is queued.
// Stall: a four-word output queue absorbs receiver back-pressure; in_ready
//   drops only when the queue plus the word in flight would overflow it.
// Reset: positions and the two pixel history registers clear, width 640,
//   height 480; the line store is not cleared, and each entry is written
//   in rows 0 and 1 of a frame before any result reads it.
// ---------------------------------------------------------------------------
module box_blur_3x3_stream
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = BB3_MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BB3_PIX_W-1:0] in_pixel,
  input  logic                 in_start_of_frame,
  // result stream
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BB3_PIX_W-1:0] out_blurred,
  output logic                 out_end_of_row,
  output logic                 out_end_of_frame,
  // configuration
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [BB3_CFG_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  // configuration registers
  logic [BB3_CFG_W-1:0] frame_width_r;
  logic [BB3_CFG_W-1:0] frame_height_r;

  // position and horizontal history
  logic [ADDR_W-1:0]    col_r,  col_nxt;
  logic [BB3_ROW_W-1:0] row_r,  row_nxt;
  logic [BB3_PIX_W-1:0] prev0_r, prev1_r;

  // stage 1: word waiting for its line store data
  logic                 s1_acc_r;   // touches the line store
  logic                 s1_prod_r;  // yields a result
  logic [ADDR_W-1:0]    s1_idx_r;
  logic [BB3_PIX_W-1:0] s1_hb_r;
  logic                 s1_eor_r;
  logic                 s1_eof_r;

  logic                 accept;
  logic [ADDR_W-1:0]    col_cur, col_last, idx;
  logic [BB3_ROW_W-1:0] row_cur, row_last;
  logic                 last_col, last_row, access, produce;
  logic [BB3_PIX_W-1:0] hb;
  logic [9:0]           vsum;
  bb3_lines_t           lines_rd, lines_wr;
  bb3_result_t          res, q_data;
  logic [BB3_Q_CNT_W-1:0] q_count;

  // ---- configuration ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= BB3_CFG_W'(BB3_WIDTH_RST);
      frame_height_r <= BB3_CFG_W'(BB3_HEIGHT_RST);
    end else if (cfg_we) begin
      unique case (bb3_cfg_idx_t'(cfg_addr))
        BB3_CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        BB3_CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped last column / last row
  always_comb begin
    priority if (frame_width_r < BB3_CFG_W'(BB3_MIN_DIM)) begin
      col_last = ADDR_W'(BB3_MIN_DIM - 1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      col_last = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      col_last = ADDR_W'(frame_width_r - BB3_CFG_W'(1));
    end
    priority if (frame_height_r < BB3_CFG_W'(BB3_MIN_DIM)) begin
      row_last = BB3_ROW_W'(BB3_MIN_DIM - 1);
    end else if (32'(frame_height_r) > BB3_MAX_HEIGHT) begin
      row_last = BB3_ROW_W'(BB3_MAX_HEIGHT - 1);
    end else begin
      row_last = BB3_ROW_W'(frame_height_r - BB3_CFG_W'(1));
    end
  end

  // ---- accept stage -------------------------------------------------------
  // keep room for the queued words plus the one in stage 1
  assign in_ready = ((q_count + BB3_Q_CNT_W'(s1_prod_r)) < BB3_Q_CNT_W'(BB3_Q_DEPTH));
  assign accept   = in_valid && in_ready;

  assign col_cur  = in_start_of_frame ? '0 : col_r;
  assign row_cur  = in_start_of_frame ? '0 : row_r;
  // a position past the (new) end counts as the end
  assign last_col = (col_cur >= col_last);
  assign last_row = (row_cur >= row_last);
  assign access   = (col_cur >= ADDR_W'(2));
  assign produce  = access && (row_cur >= BB3_ROW_W'(2));
  assign idx      = col_cur - ADDR_W'(1);   // centre column
  assign hb       = div3(10'(prev1_r) + 10'(prev0_r) + 10'(in_pixel));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_cur + BB3_ROW_W'(1);
      end else begin
        col_nxt = col_cur + ADDR_W'(1);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      prev0_r   <= '0;
      prev1_r   <= '0;
      s1_acc_r  <= 1'b0;
      s1_prod_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      s1_acc_r  <= accept && access;
      s1_prod_r <= accept && produce;
      if (accept) begin
        prev1_r <= prev0_r;
        prev0_r <= in_pixel;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r <= idx;
      s1_hb_r  <= hb;
      s1_eor_r <= last_col;
      s1_eof_r <= last_col && last_row;
    end
  end

  // ---- line store read-modify-write ---------------------------------------
  // Read at accept, write back in the following cycle. The same centre column
  // comes round again no sooner than two words later, so no forwarding.
  assign lines_wr.row_above = s1_hb_r;
  assign lines_wr.two_above = lines_rd.row_above;

  bb3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .rd_en   (accept && access),
    .rd_addr (idx),
    .rd_data (lines_rd),
    .wr_en   (s1_acc_r),
    .wr_addr (s1_idx_r),
    .wr_data (lines_wr)
  );

  // vertical average
  assign vsum             = 10'(lines_rd.two_above) + 10'(lines_rd.row_above) + 10'(s1_hb_r);
  assign res.blurred      = div3(vsum);
  assign res.end_of_row   = s1_eor_r;
  assign res.end_of_frame = s1_eof_r;

  // ---- output -------------------------------------------------------------
  bb3_out_queue u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_prod_r),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data),
    .count     (q_count)
  );

  assign out_blurred      = q_data.blurred;
  assign out_end_of_row   = q_data.end_of_row;
  assign out_end_of_frame = q_data.end_of_frame;

endmodule

// ===== src/box_blur_3x3_stream_chk.sv =====
// ---------------------------------------------------------------------------
// Box blur port checker
// Port-level checks on the blur's handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`include "box_blur_3x3_stream_assert.svh"

module box_blur_3x3_stream_chk
  import bb3_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [BB3_PIX_W-1:0] out_blurred,
  input logic                 out_end_of_row,
  input logic                 out_end_of_frame
);

  // a held result word does not change
  `BB3_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_blurred) && $stable(out_end_of_row) && $stable(out_end_of_frame))

  // frame end is always a row end
  `BB3_ASSERT_IMP(a_eof_eor, clk, rst_n, out_valid && out_end_of_frame, out_end_of_row)

  // a word on an idle output comes from an accepted input word
  `BB3_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

  // input back-pressure only while results are waiting
  `BB3_ASSERT_IMP(a_bp_cause, clk, rst_n, !in_ready, out_valid)

endmodule

bind box_blur_3x3_stream box_blur_3x3_stream_chk u_chk (.*);
